### design/directed_graph_adjacency_table_top_defines.svh
// Assertion macros shared by the graph table modules.
`ifndef DIRECTED_GRAPH_ADJACENCY_TABLE_TOP_DEFINES_SVH
`define DIRECTED_GRAPH_ADJACENCY_TABLE_TOP_DEFINES_SVH

// Property checked on every clock edge outside reset.
`define DGAT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Same-cycle implication checked outside reset.
`define DGAT_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

### design/dgat_pkg.sv
// Types, codes and constants shared by the graph table modules.
`default_nettype none

package dgat_pkg;

	localparam int NODE_SLOTS_DEF = 8;
	localparam int MAX_RESULTS    = 8;
	localparam int CNT_W          = $clog2(MAX_RESULTS + 1);
	localparam int KEY_W          = 8;
	localparam int REQ_W          = 3;
	localparam int STATUS_W       = 3;
	localparam int SLOT_OUT_W     = 3;
	localparam int MASK_OUT_W     = 8;

	typedef enum logic [REQ_W-1:0] {
		REQ_ADD_NODE   = 3'd0,
		REQ_DEL_NODE   = 3'd1,
		REQ_ADD_ARC    = 3'd2,
		REQ_DEL_ARC    = 3'd3,
		REQ_QUERY_ARC  = 3'd4,
		REQ_LIST       = 3'd5,
		REQ_LIST_SINKS = 3'd6
	} req_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 3'd0,
		ST_EXISTS    = 3'd1,
		ST_OVERFLOW  = 3'd2,
		ST_NOT_FOUND = 3'd3,
		ST_EMPTY     = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_FLUSH,
		S_EXEC,
		S_EXEC2,
		S_LIST_RD,
		S_LIST_EMIT
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic start;
		logic probe;
		logic idx_clr;
		logic idx_inc;
		logic exec_go;
		logic exec2_go;
		logic emit_go;
		logic empty_go;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic is_list;
		logic list_empty;
		logic need_b_write;
		logic idx_last;
		logic out_free;
		logic emit_match;
		logic emit_last;
	} dp_sts_t;

endpackage

`default_nettype wire

### design/directed_graph_adjacency_table_top.sv
// Directed graph table: key table plus adjacency bit matrix, top level.
//
// Each defined request first scans the key table one slot per cycle through its
// single read port, then executes; an arc add that creates both endpoints
// writes the second key in an extra state. Lists walk the slots up to the
// slot of the last result and wait on output backpressure. Undefined
// request codes are taken and dropped at once. Results leave through a
// one-entry output register, so a new request is taken while a result waits.
`default_nettype none

module directed_graph_adjacency_table_top #(
	parameter int NODE_SLOTS = dgat_pkg::NODE_SLOTS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [dgat_pkg::REQ_W-1:0]        req_type,
	input  logic [dgat_pkg::KEY_W-1:0]        key_a,
	input  logic [dgat_pkg::KEY_W-1:0]        key_b,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [dgat_pkg::STATUS_W-1:0]     status,
	output logic [dgat_pkg::KEY_W-1:0]        node_key,
	output logic [dgat_pkg::SLOT_OUT_W-1:0]   slot_index,
	output logic [dgat_pkg::MASK_OUT_W-1:0]   neighbor_mask,
	output logic                              arc_present,
	output logic                              last
);
	import dgat_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	dgat_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.req_type (req_type),
		.in_stall (in_stall),
		.cmd      (cmd),
		.sts      (sts)
	);

	dgat_dpath #(
		.NODE_SLOTS (NODE_SLOTS)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.req_type      (req_type),
		.key_a         (key_a),
		.key_b         (key_b),
		.out_stall     (out_stall),
		.out_valid     (out_valid),
		.status        (status),
		.node_key      (node_key),
		.slot_index    (slot_index),
		.neighbor_mask (neighbor_mask),
		.arc_present   (arc_present),
		.last          (last)
	);

endmodule

`default_nettype wire

### design/dgat_ctrl.sv
// Request sequencer: scan, execute and list walk control.
`default_nettype none
`include "directed_graph_adjacency_table_top_defines.svh"

module dgat_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic [dgat_pkg::REQ_W-1:0]   req_type,
	output logic                         in_stall,
	output dgat_pkg::dp_cmd_t            cmd,
	input  dgat_pkg::dp_sts_t            sts
);
	import dgat_pkg::*;

	state_t state_q;
	state_t state_nxt;
	logic   req_ok;

	assign req_ok = (req_type <= REQ_LIST_SINKS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid && req_ok) begin
					state_nxt = S_SCAN;
				end
			end
			S_SCAN: begin
				if (sts.idx_last) begin
					state_nxt = S_FLUSH;
				end
			end
			S_FLUSH: begin
				state_nxt = S_EXEC;
			end
			S_EXEC: begin
				if (sts.is_list) begin
					if (!sts.list_empty) begin
						state_nxt = S_LIST_RD;
					end else if (sts.out_free) begin
						state_nxt = S_IDLE;
					end
				end else if (sts.out_free) begin
					state_nxt = sts.need_b_write ? S_EXEC2 : S_IDLE;
				end
			end
			S_EXEC2: begin
				state_nxt = S_IDLE;
			end
			S_LIST_RD: begin
				state_nxt = S_LIST_EMIT;
			end
			S_LIST_EMIT: begin
				if (sts.emit_match) begin
					if (sts.out_free) begin
						state_nxt = (sts.emit_last || sts.idx_last) ? S_IDLE : S_LIST_RD;
					end
				end else begin
					state_nxt = sts.idx_last ? S_IDLE : S_LIST_RD;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = (state_q != S_IDLE);
		unique case (state_q)
			S_IDLE: begin
				cmd.start = in_valid && req_ok;
			end
			S_SCAN: begin
				cmd.probe   = 1'b1;
				cmd.idx_clr = sts.idx_last;
				cmd.idx_inc = !sts.idx_last;
			end
			S_EXEC: begin
				if (sts.is_list) begin
					cmd.empty_go = sts.list_empty && sts.out_free;
				end else begin
					cmd.exec_go = sts.out_free;
				end
			end
			S_EXEC2: begin
				cmd.exec2_go = 1'b1;
			end
			S_LIST_EMIT: begin
				if (sts.emit_match) begin
					cmd.emit_go = sts.out_free;
					cmd.idx_inc = sts.out_free && !sts.emit_last && !sts.idx_last;
				end else begin
					cmd.idx_inc = !sts.idx_last;
				end
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	`DGAT_ASSERT(a_one_load, $onehot0({cmd.exec_go, cmd.emit_go, cmd.empty_go}), "two result loads")
	`DGAT_ASSERT_IMPL(a_load_free, cmd.exec_go || cmd.emit_go || cmd.empty_go, sts.out_free, "result loaded over a held one")
	`DGAT_ASSERT_IMPL(a_exec2_order, state_q == S_EXEC2, $past(state_q) == S_EXEC, "second key write out of order")

endmodule

`default_nettype wire

### design/dgat_dpath.sv
// Key table, used bits, adjacency matrix, scan results and result register.
`default_nettype none
`include "directed_graph_adjacency_table_top_defines.svh"

module dgat_dpath #(
	parameter int NODE_SLOTS = dgat_pkg::NODE_SLOTS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  dgat_pkg::dp_cmd_t                 cmd,
	output dgat_pkg::dp_sts_t                 sts,
	input  logic [dgat_pkg::REQ_W-1:0]        req_type,
	input  logic [dgat_pkg::KEY_W-1:0]        key_a,
	input  logic [dgat_pkg::KEY_W-1:0]        key_b,
	input  logic                              out_stall,
	output logic                              out_valid,
	output logic [dgat_pkg::STATUS_W-1:0]     status,
	output logic [dgat_pkg::KEY_W-1:0]        node_key,
	output logic [dgat_pkg::SLOT_OUT_W-1:0]   slot_index,
	output logic [dgat_pkg::MASK_OUT_W-1:0]   neighbor_mask,
	output logic                              arc_present,
	output logic                              last
);
	import dgat_pkg::*;

	localparam int SLOT_W = $clog2(NODE_SLOTS);

	// request
	req_t              req_q;
	logic [KEY_W-1:0]  ka_q;
	logic [KEY_W-1:0]  kb_q;

	// key table
	logic [KEY_W-1:0]  slot_keys [NODE_SLOTS];
	logic [KEY_W-1:0]  rd_key_q;
	logic              kw_en;
	logic [SLOT_W-1:0] kw_addr;
	logic [KEY_W-1:0]  kw_data;

	logic [NODE_SLOTS-1:0] used_q;
	logic [NODE_SLOTS-1:0] rows_q [NODE_SLOTS];
	logic [NODE_SLOTS-1:0] used_nxt;
	logic [NODE_SLOTS-1:0] rows_nxt [NODE_SLOTS];
	logic [SLOT_W-1:0]     row_addr;
	logic [NODE_SLOTS-1:0] row_rd;

	// scan
	logic [SLOT_W-1:0] idx_q;
	logic [SLOT_W-1:0] slot_s1;
	logic              probe_s1;
	logic              sa_f_q, sb_f_q, fr1_f_q, fr2_f_q;
	logic [SLOT_W-1:0] sa_q, sb_q, fr1_q, fr2_q;
	logic [SLOT_W-1:0] bslot_q;
	logic [CNT_W-1:0]  list_cnt_q;
	logic [CNT_W-1:0]  emit_cnt_q;
	logic              list_match;
	logic              emit_last;

	// execute decode
	logic              arc_exists;
	logic              a_ok, b_ok, create_b;
	logic [SLOT_W-1:0] a_slot, b_slot;
	logic              new_a, new_b, drop_node, del_arc, set_arc;
	status_t           res_status;
	logic [SLOT_W-1:0] res_slot;
	logic              res_present;

	// result register
	logic              out_valid_q;
	status_t           status_q;
	logic [KEY_W-1:0]  node_key_q;
	logic [SLOT_OUT_W-1:0] slot_index_q;
	logic [MASK_OUT_W-1:0] mask_q;
	logic              present_q;
	logic              last_q;
	logic              out_load;
	logic              out_free;
	logic [SLOT_W-1:0] ld_slot;
	logic [SLOT_W+SLOT_OUT_W-1:0]     ld_slot_ext;
	logic [NODE_SLOTS+MASK_OUT_W-1:0] row_ext;

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			req_q <= req_t'(req_type);
			ka_q  <= key_a;
			kb_q  <= key_b;
		end
	end

	always_ff @(posedge clk) begin
		if (kw_en) begin
			slot_keys[kw_addr] <= kw_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_key_q <= slot_keys[idx_q];
		slot_s1  <= idx_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= '0;
			probe_s1 <= 1'b0;
		end else begin
			probe_s1 <= cmd.probe;
			if (cmd.start || cmd.idx_clr) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + SLOT_W'(1);
			end
		end
	end

	assign row_addr   = cmd.exec_go ? sa_q : slot_s1;
	assign row_rd     = rows_q[row_addr];
	assign list_match = used_q[slot_s1] && ((req_q == REQ_LIST) || (row_rd == '0));
	assign emit_last  = (emit_cnt_q + CNT_W'(1)) == list_cnt_q;

	// lowest matching slot for each key, two lowest free slots, list count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sa_f_q     <= 1'b0;
			sb_f_q     <= 1'b0;
			fr1_f_q    <= 1'b0;
			fr2_f_q    <= 1'b0;
			list_cnt_q <= '0;
			emit_cnt_q <= '0;
		end else if (cmd.start) begin
			sa_f_q     <= 1'b0;
			sb_f_q     <= 1'b0;
			fr1_f_q    <= 1'b0;
			fr2_f_q    <= 1'b0;
			list_cnt_q <= '0;
			emit_cnt_q <= '0;
		end else begin
			if (probe_s1) begin
				if (used_q[slot_s1]) begin
					if (!sa_f_q && rd_key_q == ka_q) begin
						sa_f_q <= 1'b1;
					end
					if (!sb_f_q && rd_key_q == kb_q) begin
						sb_f_q <= 1'b1;
					end
					if (list_match && list_cnt_q != CNT_W'(MAX_RESULTS)) begin
						list_cnt_q <= list_cnt_q + CNT_W'(1);
					end
				end else if (!fr1_f_q) begin
					fr1_f_q <= 1'b1;
				end else if (!fr2_f_q) begin
					fr2_f_q <= 1'b1;
				end
			end
			if (cmd.emit_go) begin
				emit_cnt_q <= emit_cnt_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (probe_s1) begin
			if (used_q[slot_s1]) begin
				if (!sa_f_q) begin
					sa_q <= slot_s1;
				end
				if (!sb_f_q) begin
					sb_q <= slot_s1;
				end
			end else if (!fr1_f_q) begin
				fr1_q <= slot_s1;
			end else if (!fr2_f_q) begin
				fr2_q <= slot_s1;
			end
		end
		if (cmd.exec_go) begin
			bslot_q <= b_slot;
		end
	end

	// endpoint resolution for an arc add: a new source takes the first free slot,
	// a new destination the next free one unless it is the same key
	always_comb begin
		arc_exists = sa_f_q && sb_f_q && row_rd[sb_q];
		a_ok       = sa_f_q || fr1_f_q;
		a_slot     = sa_f_q ? sa_q : fr1_q;
		if (sb_f_q) begin
			b_ok     = 1'b1;
			b_slot   = sb_q;
			create_b = 1'b0;
		end else if (ka_q == kb_q) begin
			b_ok     = a_ok;
			b_slot   = a_slot;
			create_b = 1'b0;
		end else if (sa_f_q) begin
			b_ok     = fr1_f_q;
			b_slot   = fr1_q;
			create_b = fr1_f_q;
		end else begin
			b_ok     = fr2_f_q;
			b_slot   = fr2_q;
			create_b = fr2_f_q;
		end
	end

	always_comb begin
		res_status  = ST_OK;
		res_slot    = '0;
		res_present = 1'b0;
		new_a       = 1'b0;
		new_b       = 1'b0;
		drop_node   = 1'b0;
		del_arc     = 1'b0;
		set_arc     = 1'b0;
		unique case (req_q)
			REQ_ADD_NODE: begin
				if (sa_f_q) begin
					res_status = ST_EXISTS;
					res_slot   = sa_q;
				end else if (fr1_f_q) begin
					res_slot = fr1_q;
					new_a    = 1'b1;
				end else begin
					res_status = ST_OVERFLOW;
				end
			end
			REQ_DEL_NODE: begin
				if (sa_f_q) begin
					drop_node = 1'b1;
				end else begin
					res_status = ST_NOT_FOUND;
				end
			end
			REQ_ADD_ARC: begin
				if (arc_exists) begin
					res_status = ST_EXISTS;
					res_slot   = sa_q;
				end else if (!a_ok) begin
					res_status = ST_OVERFLOW;
				end else begin
					new_a    = !sa_f_q;
					res_slot = a_slot;
					if (b_ok) begin
						new_b   = create_b;
						set_arc = 1'b1;
					end else begin
						res_status = ST_OVERFLOW;
					end
				end
			end
			REQ_DEL_ARC: begin
				res_slot = sa_f_q ? sa_q : '0;
				if (arc_exists) begin
					del_arc = 1'b1;
				end else begin
					res_status = ST_NOT_FOUND;
				end
			end
			REQ_QUERY_ARC: begin
				res_slot = sa_f_q ? sa_q : '0;
				if (sa_f_q && sb_f_q) begin
					res_present = row_rd[sb_q];
				end else begin
					res_status = ST_NOT_FOUND;
				end
			end
			default: begin
				res_status = ST_OK;
			end
		endcase
	end

	// one key write per cycle; a second new node is written the cycle after
	always_comb begin
		kw_en   = 1'b0;
		kw_addr = fr1_q;
		kw_data = ka_q;
		if (cmd.exec_go && new_a) begin
			kw_en = 1'b1;
		end else if (cmd.exec_go && new_b) begin
			kw_en   = 1'b1;
			kw_addr = b_slot;
			kw_data = kb_q;
		end else if (cmd.exec2_go) begin
			kw_en   = 1'b1;
			kw_addr = bslot_q;
			kw_data = kb_q;
		end
	end

	// next used bits and matrix rows; a node delete clears its row and column
	always_comb begin
		used_nxt = used_q;
		for (int r = 0; r < NODE_SLOTS; r++) begin
			rows_nxt[r] = rows_q[r];
		end
		if (new_a) begin
			used_nxt[fr1_q] = 1'b1;
			rows_nxt[fr1_q] = '0;
		end
		if (new_b) begin
			used_nxt[b_slot] = 1'b1;
			rows_nxt[b_slot] = '0;
		end
		if (drop_node) begin
			used_nxt[sa_q] = 1'b0;
			for (int r = 0; r < NODE_SLOTS; r++) begin
				rows_nxt[r][sa_q] = 1'b0;
			end
			rows_nxt[sa_q] = '0;
		end
		if (del_arc) begin
			rows_nxt[sa_q][sb_q] = 1'b0;
		end
		if (set_arc) begin
			rows_nxt[a_slot][b_slot] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			for (int r = 0; r < NODE_SLOTS; r++) begin
				rows_q[r] <= '0;
			end
		end else if (cmd.exec_go) begin
			used_q <= used_nxt;
			for (int r = 0; r < NODE_SLOTS; r++) begin
				rows_q[r] <= rows_nxt[r];
			end
		end
	end

	// result register
	assign out_free    = !out_valid_q || !out_stall;
	assign out_load    = cmd.exec_go || cmd.emit_go || cmd.empty_go;
	assign ld_slot     = cmd.emit_go ? slot_s1 : (cmd.exec_go ? res_slot : '0);
	assign ld_slot_ext = {{SLOT_OUT_W{1'b0}}, ld_slot};
	assign row_ext     = {{MASK_OUT_W{1'b0}}, row_rd};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			slot_index_q <= ld_slot_ext[SLOT_OUT_W-1:0];
		end
		if (cmd.exec_go) begin
			status_q   <= res_status;
			node_key_q <= ka_q;
			mask_q     <= '0;
			present_q  <= res_present;
			last_q     <= 1'b1;
		end else if (cmd.emit_go) begin
			status_q   <= ST_OK;
			node_key_q <= rd_key_q;
			mask_q     <= row_ext[MASK_OUT_W-1:0];
			present_q  <= 1'b0;
			last_q     <= emit_last;
		end else if (cmd.empty_go) begin
			status_q   <= ST_EMPTY;
			node_key_q <= '0;
			mask_q     <= '0;
			present_q  <= 1'b0;
			last_q     <= 1'b1;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign node_key      = node_key_q;
	assign slot_index    = slot_index_q;
	assign neighbor_mask = mask_q;
	assign arc_present   = present_q;
	assign last          = last_q;

	assign sts.is_list      = (req_q == REQ_LIST) || (req_q == REQ_LIST_SINKS);
	assign sts.list_empty   = (list_cnt_q == '0);
	assign sts.need_b_write = new_a && new_b;
	assign sts.idx_last     = (idx_q == SLOT_W'(NODE_SLOTS - 1));
	assign sts.out_free     = out_free;
	assign sts.emit_match   = list_match;
	assign sts.emit_last    = emit_last;

	`DGAT_ASSERT_IMPL(a_free_order, fr2_f_q, fr1_f_q && (fr1_q < fr2_q), "free slots out of order")
	`DGAT_ASSERT(a_emit_bound, emit_cnt_q <= list_cnt_q, "more list transfers than matches")
	`DGAT_ASSERT_IMPL(a_found_used, cmd.exec_go && sa_f_q, used_q[sa_q], "found slot not in use")
	`DGAT_ASSERT_IMPL(a_more_ok, out_valid_q && !last_q, status_q == ST_OK, "non-final result with bad status")

endmodule

`default_nettype wire

### sim/testbench.sv
// Self-checking testbench for the directed graph adjacency table.
module testbench;
	import dgat_pkg::*;

	localparam int NSLOTS = NODE_SLOTS_DEF;
	localparam logic [REQ_W-1:0] REQ_UNDEF = 3'd7;
	localparam int STALL_LIMIT = 2000;
	localparam int HOLD_CYCLES = 300;
	localparam int TAIL_CYCLES = 40;
	localparam int RANDOM_ITEMS = 194;
	localparam int CALM_FROM = 160;
	localparam int POOL_SIZE = 10;

	typedef struct packed {
		status_t st;
		logic [KEY_W-1:0] key;
		logic [SLOT_OUT_W-1:0] slot;
		logic [MASK_OUT_W-1:0] mask;
		logic present;
		logic lst;
	} graph_result_t;

	// Keeps its own copy of the key table and arc matrix, and the queue of
	// results the block still owes.
	class graph_model;
		logic [KEY_W-1:0] key_of [NSLOTS];
		bit used [NSLOTS];
		logic [NSLOTS-1:0] row [NSLOTS];
		graph_result_t expected_results[$];
		int errors;

		function new();
			foreach (used[s]) begin
				used[s] = 0;
				row[s] = '0;
				key_of[s] = '0;
			end
			errors = 0;
		endfunction

		function int pending();
			return expected_results.size();
		endfunction

		function int find(logic [KEY_W-1:0] key);
			for (int s = 0; s < NSLOTS; s++)
				if (used[s] && key_of[s] == key)
					return s;
			return -1;
		endfunction

		// slot of key, taking the lowest free slot if missing; -1 when full
		function int claim(logic [KEY_W-1:0] key);
			int s;
			s = find(key);
			if (s >= 0)
				return s;
			for (s = 0; s < NSLOTS; s++)
				if (!used[s]) begin
					used[s] = 1;
					key_of[s] = key;
					row[s] = '0;
					return s;
				end
			return -1;
		endfunction

		function graph_result_t mk(status_t st, logic [KEY_W-1:0] key, int slot,
				logic [MASK_OUT_W-1:0] mask, bit present, bit lst);
			graph_result_t r;
			r.st = st;
			r.key = key;
			r.slot = (slot < 0) ? '0 : slot[SLOT_OUT_W-1:0];
			r.mask = mask;
			r.present = present;
			r.lst = lst;
			return r;
		endfunction

		function void apply_request(logic [REQ_W-1:0] rt, logic [KEY_W-1:0] a,
				logic [KEY_W-1:0] b);
			int sa;
			int sb;
			int s;
			int n;
			bit have;
			graph_result_t held;
			sa = find(a);
			sb = find(b);
			case (rt)
				REQ_ADD_NODE: begin
					if (sa >= 0)
						expected_results.push_back(mk(ST_EXISTS, a, sa, '0, 0, 1));
					else begin
						s = claim(a);
						expected_results.push_back(
							mk((s < 0) ? ST_OVERFLOW : ST_OK, a, s, '0, 0, 1));
					end
				end
				REQ_DEL_NODE: begin
					if (sa < 0)
						expected_results.push_back(mk(ST_NOT_FOUND, a, -1, '0, 0, 1));
					else begin
						used[sa] = 0;
						row[sa] = '0;
						for (s = 0; s < NSLOTS; s++)
							row[s][sa] = 1'b0;
						expected_results.push_back(mk(ST_OK, a, -1, '0, 0, 1));
					end
				end
				REQ_ADD_ARC: begin
					if (sa >= 0 && sb >= 0 && row[sa][sb])
						expected_results.push_back(mk(ST_EXISTS, a, sa, '0, 0, 1));
					else begin
						sa = claim(a);
						if (sa < 0)
							expected_results.push_back(mk(ST_OVERFLOW, a, -1, '0, 0, 1));
						else begin
							sb = claim(b);
							if (sb < 0)
								expected_results.push_back(mk(ST_OVERFLOW, a, sa, '0, 0, 1));
							else begin
								row[sa][sb] = 1'b1;
								expected_results.push_back(mk(ST_OK, a, sa, '0, 0, 1));
							end
						end
					end
				end
				REQ_DEL_ARC: begin
					if (sa < 0 || sb < 0 || !row[sa][sb])
						expected_results.push_back(mk(ST_NOT_FOUND, a, sa, '0, 0, 1));
					else begin
						row[sa][sb] = 1'b0;
						expected_results.push_back(mk(ST_OK, a, sa, '0, 0, 1));
					end
				end
				REQ_QUERY_ARC: begin
					if (sa < 0 || sb < 0)
						expected_results.push_back(mk(ST_NOT_FOUND, a, sa, '0, 0, 1));
					else
						expected_results.push_back(mk(ST_OK, a, sa, '0, row[sa][sb], 1));
				end
				REQ_LIST, REQ_LIST_SINKS: begin
					have = 0;
					n = 0;
					// hold back one entry so the final one can carry last
					for (s = 0; s < NSLOTS && n < MAX_RESULTS; s++)
						if (used[s] && (rt == REQ_LIST || row[s] == '0)) begin
							if (have)
								expected_results.push_back(held);
							held = mk(ST_OK, key_of[s], s, row[s], 0, 0);
							have = 1;
							n++;
						end
					if (!have)
						held = mk(ST_EMPTY, '0, -1, '0, 0, 1);
					held.lst = 1'b1;
					expected_results.push_back(held);
				end
				default: ;
			endcase
		endfunction

		task report(string what);
			if (errors < 100)
				$display("ERROR @%0t: %s", $time, what);
			errors++;
		endtask

		task check_result(logic [STATUS_W-1:0] st, logic [KEY_W-1:0] key,
				logic [SLOT_OUT_W-1:0] slot, logic [MASK_OUT_W-1:0] mask,
				logic present, logic lst);
			graph_result_t e;
			if (expected_results.size() == 0) begin
				report($sformatf("result with none owed: st=%0d key=%02h slot=%0d",
					st, key, slot));
				return;
			end
			e = expected_results.pop_front();
			if (st !== e.st || key !== e.key || slot !== e.slot || mask !== e.mask
					|| present !== e.present || lst !== e.lst)
				report($sformatf({"got st=%0d key=%02h slot=%0d mask=%02h arc=%0b last=%0b,",
					" want st=%0d key=%02h slot=%0d mask=%02h arc=%0b last=%0b"},
					st, key, slot, mask, present, lst,
					e.st, e.key, e.slot, e.mask, e.present, e.lst));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [REQ_W-1:0] req_type = REQ_ADD_NODE;
	logic [KEY_W-1:0] key_a = '0;
	logic [KEY_W-1:0] key_b = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [STATUS_W-1:0] status;
	logic [KEY_W-1:0] node_key;
	logic [SLOT_OUT_W-1:0] slot_index;
	logic [MASK_OUT_W-1:0] neighbor_mask;
	logic arc_present;
	logic last;

	graph_model sb;
	bit calm = 0;
	bit hold_req = 0;
	int idle_cycles = 0;
	logic [KEY_W-1:0] key_pool [POOL_SIZE];
	logic [REQ_W-1:0] req_codes [8] = '{REQ_ADD_NODE, REQ_DEL_NODE, REQ_ADD_ARC,
		REQ_DEL_ARC, REQ_QUERY_ARC, REQ_LIST, REQ_LIST_SINKS, REQ_UNDEF};
	int unsigned grow_w [8] = '{15, 8, 30, 8, 20, 8, 7, 4};
	int unsigned shrink_w [8] = '{5, 35, 10, 20, 15, 7, 6, 2};

	directed_graph_adjacency_table_top u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.req_type(req_type),
		.key_a(key_a),
		.key_b(key_b),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.node_key(node_key),
		.slot_index(slot_index),
		.neighbor_mask(neighbor_mask),
		.arc_present(arc_present),
		.last(last)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			sb.apply_request(req_type, key_a, key_b);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(status, node_key, slot_index, neighbor_mask, arc_present, last);
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// receiver: random stall bursts, one long hold-off on request
	initial begin
		int hold_cnt;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				for (hold_cnt = 0; hold_cnt < HOLD_CYCLES; hold_cnt++)
					@(posedge clk);
				hold_req = 0;
				out_stall <= 1'b0;
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 11)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// Returns at the edge where the transfer happened; valid stays up.
	task automatic send_request(logic [REQ_W-1:0] rt, logic [KEY_W-1:0] a,
			logic [KEY_W-1:0] b);
		if (!calm && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= rt;
		key_a <= a;
		key_b <= b;
		do @(posedge clk); while (in_stall);
	endtask

	function automatic logic [KEY_W-1:0] pick_key();
		if ($urandom_range(0, 7) == 0)
			return KEY_W'($urandom_range(0, 255));
		return key_pool[$urandom_range(0, POOL_SIZE - 1)];
	endfunction

	initial begin
		int unsigned roll;
		int k;
		bit shrink;
		sb = new();
		foreach (key_pool[i])
			key_pool[i] = KEY_W'($urandom_range(0, 255));
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty table, duplicates, self arc, full table, deletes
		send_request(REQ_LIST, 8'h00, 8'h00);
		send_request(REQ_LIST_SINKS, 8'h00, 8'h00);
		send_request(REQ_DEL_NODE, 8'h00, 8'h00);
		send_request(REQ_QUERY_ARC, 8'h00, 8'hFF);
		send_request(REQ_ADD_NODE, 8'h00, 8'hFF);
		send_request(REQ_ADD_NODE, 8'h00, 8'h00);
		send_request(REQ_ADD_ARC, 8'h00, 8'hFF);
		send_request(REQ_ADD_ARC, 8'h00, 8'hFF);
		send_request(REQ_ADD_ARC, 8'hFF, 8'hFF);
		send_request(REQ_QUERY_ARC, 8'hFF, 8'hFF);
		send_request(REQ_ADD_ARC, 8'h5A, 8'hA5);
		send_request(REQ_LIST_SINKS, 8'h00, 8'h00);
		for (k = 1; k <= 4; k++)
			send_request(REQ_ADD_NODE, KEY_W'(k), KEY_W'(k));
		send_request(REQ_ADD_NODE, 8'h07, 8'h00);
		// full table: neither endpoint fits
		send_request(REQ_ADD_ARC, 8'h10, 8'h11);
		send_request(REQ_DEL_ARC, 8'h00, 8'hFF);
		send_request(REQ_DEL_ARC, 8'h00, 8'hFF);
		send_request(REQ_DEL_NODE, 8'hFF, 8'h00);
		// source takes the freed slot, destination overflows
		send_request(REQ_ADD_ARC, 8'h20, 8'h21);
		send_request(REQ_LIST, 8'h00, 8'h00);
		send_request(REQ_UNDEF, 8'hFF, 8'hFF);
		send_request(REQ_DEL_NODE, 8'h20, 8'h00);
		send_request(REQ_LIST_SINKS, 8'h00, 8'h00);

		hold_req = 1;
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == CALM_FROM)
				calm = 1;
			// alternate growing and shrinking phases so the table both fills and empties
			shrink = ((i / 40) % 2) == 1;
			roll = $urandom_range(0, 99);
			for (k = 0; k < 7; k++) begin
				if (roll < (shrink ? shrink_w[k] : grow_w[k]))
					break;
				roll -= shrink ? shrink_w[k] : grow_w[k];
			end
			send_request(req_codes[k], pick_key(), pick_key());
		end
		in_valid <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule
